/* sv/cbm_pkg.sv */
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared constants, types and step functions of the circular brush mask
// generator: field widths, register indexes, and single steps of the square
// root and division pipelines.
// ----------------------------------------------------------------------------
package cbm_pkg;

   localparam int MAX_SIDE  = 256;
   localparam int ALPHA_MAX = 65535;

   localparam int PIX_W      = 8;
   localparam int WIDTH_W    = 9;
   localparam int CHAN_W     = 16;
   localparam int ALPHA_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int WCAP_INT = (MAX_SIDE < (2 ** WIDTH_W - 1)) ? MAX_SIDE : (2 ** WIDTH_W - 1);
   localparam logic [WIDTH_W-1:0] W_CAP = WCAP_INT[WIDTH_W-1:0];
   localparam logic [ALPHA_W-1:0] ALPHA_FULL = ALPHA_MAX[ALPHA_W-1:0];

   localparam int DIFF_W     = PIX_W + 2;
   localparam int SQ_W       = 2 * DIFF_W;
   localparam int SUM_W      = SQ_W + 1;
   localparam int WSQ_W      = 2 * WIDTH_W;
   localparam int FRAC_SHIFT = 14;
   localparam int ROOT_W     = (SUM_W + FRAC_SHIFT + 1) / 2;
   localparam int RADP_W     = 2 * ROOT_W;
   localparam int REM_W      = ROOT_W + 3;
   localparam int RADQ_W     = WIDTH_W + 7;
   localparam int PROD_W     = 2 * ALPHA_W;
   localparam int QUO_W      = ALPHA_W;
   localparam int DREM_W     = WIDTH_W + 1;

   localparam int LATENCY = 4 + ROOT_W + 2 + QUO_W + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BRUSH_WIDTH  = 3'd0,
      CSR_BRUSH_HEIGHT = 3'd1,
      CSR_FEATHER_ON   = 3'd2,
      CSR_RED          = 3'd3,
      CSR_GREEN        = 3'd4,
      CSR_BLUE         = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic in_circle;
      logic last;
   } tag_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [RADP_W-1:0] rad;
   } sqrt_stage_type;

   typedef struct packed {
      logic [DREM_W-1:0] rem;
      logic [QUO_W-1:0]  quo;
      logic [QUO_W-1:0]  low;
   } div_stage_type;

   function automatic sqrt_stage_type isqrt_step(input sqrt_stage_type prev);
      logic [REM_W-1:0] cur;
      logic [REM_W-1:0] trial;
      logic             ge;
      sqrt_stage_type   nxt;
      cur      = {prev.rem[REM_W-3:0], prev.rad[RADP_W-1 -: 2]};
      trial    = {{(REM_W-ROOT_W-2){1'b0}}, prev.root, 2'b01};
      ge       = (cur >= trial);
      nxt.rem  = ge ? (cur - trial) : cur;
      nxt.root = {prev.root[ROOT_W-2:0], ge};
      nxt.rad  = {prev.rad[RADP_W-3:0], 2'b00};
      return nxt;
   endfunction

   function automatic div_stage_type div_step(input div_stage_type prev,
                                              input logic [WIDTH_W-1:0] divisor);
      logic [DREM_W-1:0] cur;
      logic [DREM_W-1:0] dext;
      logic              ge;
      div_stage_type     nxt;
      cur     = {prev.rem[DREM_W-2:0], prev.low[QUO_W-1]};
      dext    = {1'b0, divisor};
      ge      = (cur >= dext);
      nxt.rem = ge ? (cur - dext) : cur;
      nxt.quo = {prev.quo[QUO_W-2:0], ge};
      nxt.low = {prev.low[QUO_W-2:0], 1'b0};
      return nxt;
   endfunction

endpackage

/* sv/circular_brush_mask_generator_core.sv */
// ----------------------------------------------------------------------------
// circular_brush_mask_generator_core
// Computes one pixel of a circular brush stamp per item: the paint colour,
// an alpha that is zero outside the circle and full or linearly feathered
// inside, and a flag for the final pixel of the brush.
// ----------------------------------------------------------------------------
// An item (req_column, req_row) is taken at a rising edge where start is high
// and busy is low. Busy is high only in reset and the cycle after it, so a
// new item may be offered in every cycle and one item per clock is sustained.
// Each item yields one result on the rsp_ ports, marked by rsp_valid for a
// single cycle. It passes the input, difference, square and sum registers,
// the 18-stage square root, the falloff and product registers, the 16-stage
// divider and the output register, the two pipes resolving one bit per stage.
// The receiver cannot stall, so the pipeline always advances.
// The configuration registers are written through the csr_ port and should be
// changed only when no item is in flight; the colour outputs follow them.
// Reset clears every pipeline valid bit, discarding items in flight, and
// returns the registers to width and height 1, feathering off, black.
// ----------------------------------------------------------------------------
module circular_brush_mask_generator_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [cbm_pkg::PIX_W-1:0]         req_column,
   input  logic [cbm_pkg::PIX_W-1:0]         req_row,
   output logic                              rsp_valid,
   output logic [cbm_pkg::CHAN_W-1:0]        rsp_out_red,
   output logic [cbm_pkg::CHAN_W-1:0]        rsp_out_green,
   output logic [cbm_pkg::CHAN_W-1:0]        rsp_out_blue,
   output logic [cbm_pkg::ALPHA_W-1:0]       rsp_alpha,
   output logic                              rsp_last_pixel,
   input  logic                              csr_write_enable,
   input  logic [cbm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cbm_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   logic                            busy_ff;
   logic                            accept;

   logic [cbm_pkg::WIDTH_W-1:0]     brush_width_ff;
   logic [cbm_pkg::WIDTH_W-1:0]     brush_height_ff;
   logic                            feather_on_ff;
   logic [cbm_pkg::CHAN_W-1:0]      red_ff;
   logic [cbm_pkg::CHAN_W-1:0]      green_ff;
   logic [cbm_pkg::CHAN_W-1:0]      blue_ff;

   logic [cbm_pkg::WIDTH_W-1:0]     w_sat;
   logic [cbm_pkg::WIDTH_W-1:0]     h_sat;

   logic                            s0_valid_ff;
   logic [cbm_pkg::PIX_W-1:0]       s0_column_ff;
   logic [cbm_pkg::PIX_W-1:0]       s0_row_ff;

   logic [cbm_pkg::DIFF_W-1:0]      two_c;
   logic [cbm_pkg::DIFF_W-1:0]      two_r;
   logic [cbm_pkg::DIFF_W-1:0]      w_ext;
   logic [cbm_pkg::DIFF_W-1:0]      dx_in;
   logic [cbm_pkg::DIFF_W-1:0]      dy_in;
   logic                            last_in;
   logic                            s1_valid_ff;
   logic [cbm_pkg::DIFF_W-1:0]      dx_ff;
   logic [cbm_pkg::DIFF_W-1:0]      dy_ff;
   logic                            s1_last_ff;

   logic                            s2_valid_ff;
   logic [cbm_pkg::SQ_W-1:0]        sqx_ff;
   logic [cbm_pkg::SQ_W-1:0]        sqy_ff;
   logic [cbm_pkg::WSQ_W-1:0]       wsq_ff;
   logic                            s2_last_ff;

   logic [cbm_pkg::SUM_W-1:0]       sum_in;
   cbm_pkg::tag_type                s3_tag_in;
   cbm_pkg::tag_type                s3_tag_ff;
   logic [cbm_pkg::SUM_W-1:0]       sum_ff;
   logic [cbm_pkg::RADP_W-1:0]      radicand;

   cbm_pkg::tag_type                sqrt_tag;
   logic [cbm_pkg::ROOT_W-1:0]      sqrt_root;

   logic [cbm_pkg::RADQ_W-1:0]      rad_q;
   cbm_pkg::tag_type                s4_tag_ff;
   logic [cbm_pkg::RADQ_W-1:0]      diff_ff;

   cbm_pkg::tag_type                s5_tag_ff;
   logic [cbm_pkg::PROD_W-1:0]      prod_ff;

   cbm_pkg::tag_type                div_tag;
   logic [cbm_pkg::QUO_W-1:0]       div_quotient;

   logic [cbm_pkg::ALPHA_W-1:0]     alpha_in;
   logic                            rsp_valid_ff;
   logic [cbm_pkg::ALPHA_W-1:0]     rsp_alpha_ff;
   logic                            rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b1;
         brush_width_ff  <= {{(cbm_pkg::WIDTH_W-1){1'b0}}, 1'b1};
         brush_height_ff <= {{(cbm_pkg::WIDTH_W-1){1'b0}}, 1'b1};
         feather_on_ff   <= 1'b0;
         red_ff          <= '0;
         green_ff        <= '0;
         blue_ff         <= '0;
      end else begin
         busy_ff <= 1'b0;
         if (csr_write_enable) begin
            case (csr_index)
               cbm_pkg::CSR_BRUSH_WIDTH: begin
                  brush_width_ff <= csr_write_data[cbm_pkg::WIDTH_W-1:0];
               end
               cbm_pkg::CSR_BRUSH_HEIGHT: begin
                  brush_height_ff <= csr_write_data[cbm_pkg::WIDTH_W-1:0];
               end
               cbm_pkg::CSR_FEATHER_ON: begin
                  feather_on_ff <= csr_write_data[0];
               end
               cbm_pkg::CSR_RED: begin
                  red_ff <= csr_write_data[cbm_pkg::CHAN_W-1:0];
               end
               cbm_pkg::CSR_GREEN: begin
                  green_ff <= csr_write_data[cbm_pkg::CHAN_W-1:0];
               end
               cbm_pkg::CSR_BLUE: begin
                  blue_ff <= csr_write_data[cbm_pkg::CHAN_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   assign w_sat = (brush_width_ff > cbm_pkg::W_CAP) ? cbm_pkg::W_CAP : brush_width_ff;
   assign h_sat = (brush_height_ff > cbm_pkg::W_CAP) ? cbm_pkg::W_CAP : brush_height_ff;

   always_comb begin
      two_c   = {1'b0, s0_column_ff, 1'b0};
      two_r   = {1'b0, s0_row_ff, 1'b0};
      w_ext   = {{(cbm_pkg::DIFF_W-cbm_pkg::WIDTH_W){1'b0}}, w_sat};
      dx_in   = (two_c >= w_ext) ? (two_c - w_ext) : (w_ext - two_c);
      dy_in   = (two_r >= w_ext) ? (two_r - w_ext) : (w_ext - two_r);
      last_in = (({1'b0, s0_column_ff} + {{(cbm_pkg::WIDTH_W-1){1'b0}}, 1'b1}) == w_sat)
             && (({1'b0, s0_row_ff} + {{(cbm_pkg::WIDTH_W-1){1'b0}}, 1'b1}) == h_sat);
   end

   always_comb begin
      sum_in              = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      s3_tag_in.valid     = s2_valid_ff;
      s3_tag_in.last      = s2_last_ff;
      s3_tag_in.in_circle = (w_sat != '0)
                         && (sum_in <= {{(cbm_pkg::SUM_W-cbm_pkg::WSQ_W){1'b0}}, wsq_ff});
   end

   assign radicand = {{(cbm_pkg::RADP_W-cbm_pkg::SUM_W-cbm_pkg::FRAC_SHIFT){1'b0}},
                      sum_ff, {cbm_pkg::FRAC_SHIFT{1'b0}}};
   assign rad_q    = {w_sat, 7'b0000000};

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff     <= 1'b0;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         s3_tag_ff.valid <= 1'b0;
         s4_tag_ff.valid <= 1'b0;
         s5_tag_ff.valid <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         s0_valid_ff  <= accept;
         s0_column_ff <= req_column;
         s0_row_ff    <= req_row;

         s1_valid_ff  <= s0_valid_ff;
         dx_ff        <= dx_in;
         dy_ff        <= dy_in;
         s1_last_ff   <= last_in;

         s2_valid_ff  <= s1_valid_ff;
         sqx_ff       <= dx_ff * dx_ff;
         sqy_ff       <= dy_ff * dy_ff;
         wsq_ff       <= w_sat * w_sat;
         s2_last_ff   <= s1_last_ff;

         s3_tag_ff    <= s3_tag_in;
         sum_ff       <= sum_in;

         s4_tag_ff    <= sqrt_tag;
         diff_ff      <= sqrt_tag.in_circle ? (rad_q - sqrt_root[cbm_pkg::RADQ_W-1:0]) : '0;

         s5_tag_ff    <= s4_tag_ff;
         prod_ff      <= cbm_pkg::ALPHA_FULL * diff_ff;

         rsp_valid_ff <= div_tag.valid;
         rsp_alpha_ff <= alpha_in;
         rsp_last_ff  <= div_tag.last;
      end
   end

   cbm_isqrt_pipe u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .in_tag      (s3_tag_ff),
      .in_radicand (radicand),
      .out_tag     (sqrt_tag),
      .out_root    (sqrt_root)
   );

   cbm_div_pipe u_div (
      .clock        (clock),
      .reset        (reset),
      .in_tag       (s5_tag_ff),
      .in_product   (prod_ff),
      .in_divisor   (w_sat),
      .out_tag      (div_tag),
      .out_quotient (div_quotient)
   );

   always_comb begin
      if (!div_tag.in_circle) begin
         alpha_in = '0;
      end else if (feather_on_ff) begin
         alpha_in = div_quotient;
      end else begin
         alpha_in = cbm_pkg::ALPHA_FULL;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_alpha      = rsp_alpha_ff;
   assign rsp_last_pixel = rsp_last_ff;
   assign rsp_out_red    = red_ff;
   assign rsp_out_green  = green_ff;
   assign rsp_out_blue   = blue_ff;

   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, cbm_pkg::LATENCY))
      else $error("result strobed without an item accepted at the pipeline latency");

   a_reset_flushes: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobed straight after reset");

   a_busy_empty: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid && !s0_valid_ff)
      else $error("pipeline not empty while busy after reset");

endmodule

/* sv/cbm_isqrt_pipe.sv */
// ----------------------------------------------------------------------------
// cbm_isqrt_pipe
// Pipelined integer square root, one result bit per register stage, with the
// item tag carried alongside.
// ----------------------------------------------------------------------------
module cbm_isqrt_pipe (
   input  logic                            clock,
   input  logic                            reset,
   input  cbm_pkg::tag_type                in_tag,
   input  logic [cbm_pkg::RADP_W-1:0]      in_radicand,
   output cbm_pkg::tag_type                out_tag,
   output logic [cbm_pkg::ROOT_W-1:0]      out_root
);

   cbm_pkg::sqrt_stage_type stage_in [cbm_pkg::ROOT_W];
   cbm_pkg::sqrt_stage_type stage_ff [cbm_pkg::ROOT_W];
   cbm_pkg::tag_type        tag_ff   [cbm_pkg::ROOT_W];
   cbm_pkg::sqrt_stage_type first;

   always_comb begin
      first.rem  = '0;
      first.root = '0;
      first.rad  = in_radicand;
      stage_in[0] = cbm_pkg::isqrt_step(first);
      for (int i = 1; i < cbm_pkg::ROOT_W; i++) begin
         stage_in[i] = cbm_pkg::isqrt_step(stage_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cbm_pkg::ROOT_W; i++) begin
            tag_ff[i].valid <= 1'b0;
         end
      end else begin
         stage_ff  <= stage_in;
         tag_ff[0] <= in_tag;
         for (int i = 1; i < cbm_pkg::ROOT_W; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   assign out_tag  = tag_ff[cbm_pkg::ROOT_W-1];
   assign out_root = stage_ff[cbm_pkg::ROOT_W-1].root;

endmodule

/* sv/cbm_div_pipe.sv */
// ----------------------------------------------------------------------------
// cbm_div_pipe
// Pipelined restoring division of the scaled falloff product by the brush
// width, one quotient bit per register stage, with the item tag alongside.
// ----------------------------------------------------------------------------
module cbm_div_pipe (
   input  logic                            clock,
   input  logic                            reset,
   input  cbm_pkg::tag_type                in_tag,
   input  logic [cbm_pkg::PROD_W-1:0]      in_product,
   input  logic [cbm_pkg::WIDTH_W-1:0]     in_divisor,
   output cbm_pkg::tag_type                out_tag,
   output logic [cbm_pkg::QUO_W-1:0]       out_quotient
);

   cbm_pkg::div_stage_type stage_in [cbm_pkg::QUO_W];
   cbm_pkg::div_stage_type stage_ff [cbm_pkg::QUO_W];
   cbm_pkg::tag_type       tag_ff   [cbm_pkg::QUO_W];
   cbm_pkg::div_stage_type first;

   // The product is divided by 128 first; its top bits are already below
   // the divisor, so only the low quotient bits need a step each.
   always_comb begin
      first.rem = {1'b0, in_product[cbm_pkg::PROD_W-1 -: cbm_pkg::WIDTH_W]};
      first.quo = '0;
      first.low = in_product[cbm_pkg::PROD_W-cbm_pkg::WIDTH_W-1 -: cbm_pkg::QUO_W];
      stage_in[0] = cbm_pkg::div_step(first, in_divisor);
      for (int i = 1; i < cbm_pkg::QUO_W; i++) begin
         stage_in[i] = cbm_pkg::div_step(stage_ff[i-1], in_divisor);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cbm_pkg::QUO_W; i++) begin
            tag_ff[i].valid <= 1'b0;
         end
      end else begin
         stage_ff  <= stage_in;
         tag_ff[0] <= in_tag;
         for (int i = 1; i < cbm_pkg::QUO_W; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   assign out_tag      = tag_ff[cbm_pkg::QUO_W-1];
   assign out_quotient = stage_ff[cbm_pkg::QUO_W-1].quo;

endmodule

/* test/circular_brush_mask_generator_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_brush_mask_generator_core_tb
// Self-checking bench for the brush mask core. A short directed table covers
// the state after reset, the edges and centre of the largest brush, feathering,
// oversized, zero and tiny brush sizes, pixels beyond the brush and writes to
// unused register slots. Random phases then reprogram every register and send
// bursts of pixels, mostly inside the brush. Every result's colour, alpha and
// last-pixel flag are checked against the table or a behavioural prediction.
// ----------------------------------------------------------------------------
module circular_brush_mask_generator_core_tb;

   localparam int DRAIN_CYCLES = 64;
   localparam int PHASE_COUNT = 9;
   localparam int PHASE_PIXELS = 205;
   localparam int DIRECTED_ROWS = 35;
   localparam logic [cbm_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [cbm_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   typedef struct {
      logic [cbm_pkg::CHAN_W-1:0]  red;
      logic [cbm_pkg::CHAN_W-1:0]  green;
      logic [cbm_pkg::CHAN_W-1:0]  blue;
      logic [cbm_pkg::ALPHA_W-1:0] alpha;
      logic                        last;
   } pixel_result_type;

   typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_type;

   typedef struct packed {
      row_kind_type                    kind;
      logic [cbm_pkg::CSR_IDX_W-1:0]   index;
      logic [cbm_pkg::CSR_DATA_W-1:0]  data;
      logic [cbm_pkg::PIX_W-1:0]       column;
      logic [cbm_pkg::PIX_W-1:0]       row;
      logic                            known;
      logic [cbm_pkg::ALPHA_W-1:0]     alpha;
      logic                            last;
   } stim_row_type;

   logic                           clock;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic [cbm_pkg::PIX_W-1:0]      req_column = '0;
   logic [cbm_pkg::PIX_W-1:0]      req_row = '0;
   logic                           rsp_valid;
   logic [cbm_pkg::CHAN_W-1:0]     rsp_out_red;
   logic [cbm_pkg::CHAN_W-1:0]     rsp_out_green;
   logic [cbm_pkg::CHAN_W-1:0]     rsp_out_blue;
   logic [cbm_pkg::ALPHA_W-1:0]    rsp_alpha;
   logic                           rsp_last_pixel;
   logic                           csr_write_enable = 1'b0;
   logic [cbm_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [cbm_pkg::CSR_DATA_W-1:0] csr_write_data = '0;

   logic [cbm_pkg::WIDTH_W-1:0] brush_width_q = 9'd1;
   logic [cbm_pkg::WIDTH_W-1:0] brush_height_q = 9'd1;
   logic                        feather_q = 1'b0;
   logic [cbm_pkg::CHAN_W-1:0]  paint_red = '0;
   logic [cbm_pkg::CHAN_W-1:0]  paint_green = '0;
   logic [cbm_pkg::CHAN_W-1:0]  paint_blue = '0;

   pixel_result_type pending_pixels[$];
   int mismatches = 0;
   int pixels_sent = 0;
   int inside_count = 0;
   int last_count = 0;
   int register_writes = 0;
   int burst_left = 0;

   stim_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{ROW_PIXEL, 3'd0, 16'h0000, 8'd0, 8'd0, 1'b1, 16'h0000, 1'b1},
      '{ROW_PIXEL, 3'd0, 16'h0000, 8'd255, 8'd255, 1'b1, 16'h0000, 1'b0},
      '{ROW_WRITE, cbm_pkg::CSR_BRUSH_WIDTH, 16'hFFFF, 8'd0, 8'd0, 1'b0, 16'h0000, 1'b0},
      '{ROW_WRITE, cbm_pkg::CSR_BRUSH_HEIGHT, 16'h0100, 8'd0, 8'd0, 1'b0, 16'h0000, 1'b0},
      '{ROW_WRITE, cbm_pkg::CSR_RED, 16'hFFFF, 8'd0, 8'd0, 1'b0, 16'h0000, 1'b0},
      '{ROW_WRITE, cbm_pkg::CSR_GREEN, 16'h5A5A, 8'd0, 8'd0, 1'b0, 16'h0000, 1'b0},
      '{ROW_WRITE, cbm_pkg::CSR_BLUE, 16'hA5A5, 8'd0, 8'd0, 1'b0, 16'h0000, 1'b0},
      '{ROW_PIXEL, 3'd0, 16'h0000, 8'd128, 8'd128, 1'b1, 16'hFFFF, 1'b0},
      '{ROW_PIXEL, 3'd0, 16'h0000, 8'd0, 8'd128, 1'b1, 16'hFFFF, 1'b0},
      '{ROW_PIXEL, 3'd0, 16'h0000, 8'd0, 8'd0, 1'b1, 16'h0000, 1'b0},
      '{ROW_PIXEL, 3'd0, 16'h0000, 8'd255, 8'd255, 1'b1, 16'h0000, 1'b1},
      '{ROW_WRITE, cbm_pkg::CSR_FEATHER_ON, 16'h0001, 8'd0, 8'd0, 1'b0, 16'h0000, 1'b0},
      '{ROW_PIXEL, 3'd0, 16'h0000, 8'd128, 8'd128, 1'b1, 16'hFFFF, 1'b0},
      '{ROW_PIXEL, 3'd0, 16'h0000, 8'd0, 8'd128, 1'b1, 16'h0000, 1'b0},
      '{ROW_PIXEL, 3'd0, 16'h0000, 8'd64, 8'd128, 1'b0, 16'h0000, 1'b0},
      '{ROW_PIXEL, 3'd0, 16'h0000, 8'd255, 8'd255, 1'b1, 16'h0000, 1'b1},
      '{ROW_WRITE, cbm_pkg::CSR_BRUSH_WIDTH, 16'h0000, 8'd0, 8'd0, 1'b0, 16'h0000, 1'b0},
      '{ROW_PIXEL, 3'd0, 16'h0000, 8'd0, 8'd0, 1'b1, 16'h0000, 1'b0},
      '{ROW_PIXEL, 3'd0, 16'h0000, 8'd255, 8'd0, 1'b1, 16'h0000, 1'b0},
      '{ROW_WRITE, cbm_pkg::CSR_BRUSH_WIDTH, 16'h0001, 8'd0, 8'd0, 1'b0, 16'h0000, 1'b0},
      '{ROW_WRITE, cbm_pkg::CSR_BRUSH_HEIGHT, 16'h0000, 8'd0, 8'd0, 1'b0, 16'h0000, 1'b0},
      '{ROW_PIXEL, 3'd0, 16'h0000, 8'd0, 8'd0, 1'b1, 16'h0000, 1'b0},
      '{ROW_WRITE, cbm_pkg::CSR_BRUSH_WIDTH, 16'h0004, 8'd0, 8'd0, 1'b0, 16'h0000, 1'b0},
      '{ROW_WRITE, cbm_pkg::CSR_BRUSH_HEIGHT, 16'h0004, 8'd0, 8'd0, 1'b0, 16'h0000, 1'b0},
      '{ROW_PIXEL, 3'd0, 16'h0000, 8'd200, 8'd3, 1'b1, 16'h0000, 1'b0},
      '{ROW_PIXEL, 3'd0, 16'h0000, 8'd3, 8'd3, 1'b0, 16'h0000, 1'b0},
      '{ROW_PIXEL, 3'd0, 16'h0000, 8'd2, 8'd2, 1'b1, 16'hFFFF, 1'b0},
      '{ROW_WRITE, cbm_pkg::CSR_BRUSH_WIDTH, 16'h0002, 8'd0, 8'd0, 1'b0, 16'h0000, 1'b0},
      '{ROW_WRITE, cbm_pkg::CSR_BRUSH_HEIGHT, 16'h0002, 8'd0, 8'd0, 1'b0, 16'h0000, 1'b0},
      '{ROW_WRITE, cbm_pkg::CSR_FEATHER_ON, 16'hFFFE, 8'd0, 8'd0, 1'b0, 16'h0000, 1'b0},
      '{ROW_PIXEL, 3'd0, 16'h0000, 8'd1, 8'd1, 1'b1, 16'hFFFF, 1'b1},
      '{ROW_PIXEL, 3'd0, 16'h0000, 8'd0, 8'd0, 1'b1, 16'h0000, 1'b0},
      '{ROW_WRITE, CSR_SPARE_A, 16'hFFFF, 8'd0, 8'd0, 1'b0, 16'h0000, 1'b0},
      '{ROW_WRITE, CSR_SPARE_B, 16'h0000, 8'd0, 8'd0, 1'b0, 16'h0000, 1'b0},
      '{ROW_PIXEL, 3'd0, 16'h0000, 8'd1, 8'd0, 1'b0, 16'h0000, 1'b0}
   };

   circular_brush_mask_generator_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_column       (req_column),
      .req_row          (req_row),
      .rsp_valid        (rsp_valid),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_alpha        (rsp_alpha),
      .rsp_last_pixel   (rsp_last_pixel),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic pixel_result_type predict_pixel(input logic [cbm_pkg::PIX_W-1:0] c,
                                                      input logic [cbm_pkg::PIX_W-1:0] r);
      int unsigned ci, ri, w, h, dx, dy, s, rad, dq, trial;
      longint unsigned scaled, quotient;
      pixel_result_type res;
      ci = c;
      ri = r;
      w = (brush_width_q > cbm_pkg::MAX_SIDE) ? cbm_pkg::MAX_SIDE : brush_width_q;
      h = (brush_height_q > cbm_pkg::MAX_SIDE) ? cbm_pkg::MAX_SIDE : brush_height_q;
      res.red = paint_red;
      res.green = paint_green;
      res.blue = paint_blue;
      res.alpha = '0;
      if (w != 0) begin
         dx = (2 * ci >= w) ? 2 * ci - w : w - 2 * ci;
         dy = (2 * ri >= w) ? 2 * ri - w : w - 2 * ri;
         s = dx * dx + dy * dy;
         if (s <= w * w) begin
            if (feather_q) begin
               rad = 128 * w;
               scaled = longint'(s) << 14;
               dq = 0;
               for (int b = 20; b >= 0; b--) begin
                  trial = dq | (32'd1 << b);
                  if (longint'(trial) * longint'(trial) <= scaled) dq = trial;
               end
               if (dq > rad) dq = rad;
               quotient = (longint'(cbm_pkg::ALPHA_MAX) * longint'(rad - dq)) / longint'(rad);
               res.alpha = quotient[cbm_pkg::ALPHA_W-1:0];
            end else begin
               res.alpha = cbm_pkg::ALPHA_FULL;
            end
         end
      end
      res.last = (ci + 1 == w) && (ri + 1 == h);
      return res;
   endfunction

   task automatic send_pixel(input logic [cbm_pkg::PIX_W-1:0] c,
                             input logic [cbm_pkg::PIX_W-1:0] r,
                             input logic known, input logic [cbm_pkg::ALPHA_W-1:0] alpha,
                             input logic last);
      pixel_result_type expected;
      req_column <= c;
      req_row <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      expected = predict_pixel(c, r);
      if (known) begin
         expected.alpha = alpha;
         expected.last = last;
      end
      pending_pixels.push_back(expected);
      pixels_sent++;
      if (expected.alpha != 0) inside_count++;
      if (expected.last) last_count++;
   endtask

   task automatic rest(input int unsigned cycles);
      if (cycles != 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic write_register(input logic [cbm_pkg::CSR_IDX_W-1:0] index,
                                 input logic [cbm_pkg::CSR_DATA_W-1:0] data);
      start <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      register_writes++;
      case (index)
         cbm_pkg::CSR_BRUSH_WIDTH:  brush_width_q = data[cbm_pkg::WIDTH_W-1:0];
         cbm_pkg::CSR_BRUSH_HEIGHT: brush_height_q = data[cbm_pkg::WIDTH_W-1:0];
         cbm_pkg::CSR_FEATHER_ON:   feather_q = data[0];
         cbm_pkg::CSR_RED:          paint_red = data;
         cbm_pkg::CSR_GREEN:        paint_green = data;
         cbm_pkg::CSR_BLUE:         paint_blue = data;
         default: ;
      endcase
   endtask

   task automatic run_phase(input int unsigned kind, input int unsigned count);
      logic [cbm_pkg::WIDTH_W-1:0] w9;
      logic [cbm_pkg::WIDTH_W-1:0] h9;
      logic                        feather;
      int unsigned                 span_c, span_r;
      logic [cbm_pkg::PIX_W-1:0]   c, r;
      case (kind)
         0: begin
            w9 = 9'd256;
            h9 = 9'd256;
            feather = 1'b1;
         end
         1: begin
            w9 = 9'd1;
            h9 = 9'd1;
            feather = 1'b0;
         end
         2: begin
            w9 = 9'h1FF;
            h9 = 9'($urandom_range(0, 511));
            feather = 1'($urandom);
         end
         3: begin
            w9 = 9'($urandom_range(0, 511));
            h9 = 9'($urandom_range(0, 511));
            feather = 1'b1;
         end
         default: begin
            w9 = 9'($urandom_range(1, 40));
            h9 = ($urandom_range(0, 1) == 0) ? w9 : 9'($urandom_range(1, 40));
            feather = 1'($urandom);
         end
      endcase
      write_register(cbm_pkg::CSR_BRUSH_WIDTH, {7'($urandom), w9});
      write_register(cbm_pkg::CSR_BRUSH_HEIGHT, {7'($urandom), h9});
      write_register(cbm_pkg::CSR_FEATHER_ON, {15'($urandom), feather});
      write_register(cbm_pkg::CSR_RED, 16'($urandom));
      write_register(cbm_pkg::CSR_GREEN, 16'($urandom));
      write_register(cbm_pkg::CSR_BLUE, 16'($urandom));
      if ($urandom_range(0, 2) == 0)
         write_register($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, 16'($urandom));
      span_c = (w9 > cbm_pkg::MAX_SIDE) ? cbm_pkg::MAX_SIDE : ((w9 == 0) ? 1 : w9);
      span_r = (h9 > cbm_pkg::MAX_SIDE) ? cbm_pkg::MAX_SIDE : ((h9 == 0) ? 1 : h9);
      burst_left = $urandom_range(1, 48);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 6) == 0) begin
            c = 8'($urandom);
            r = 8'($urandom);
         end else begin
            c = 8'($urandom_range(0, span_c - 1));
            r = 8'($urandom_range(0, span_r - 1));
         end
         send_pixel(c, r, 1'b0, '0, 1'b0);
         // The first phase keeps start high throughout to test back-to-back items.
         if (kind != 0) begin
            burst_left--;
            if (burst_left == 0) begin
               rest(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
               burst_left = $urandom_range(1, 48);
            end
         end
      end
   endtask

   task automatic check_field(input string name, input logic [cbm_pkg::CHAN_W-1:0] expected,
                              input logic [cbm_pkg::CHAN_W-1:0] actual);
      if (actual !== expected) begin
         $error("%s: expected %h, got %h", name, expected, actual);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      pixel_result_type expected;
      if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            $error("rsp_valid: expected no result, got one");
            mismatches++;
         end else begin
            expected = pending_pixels.pop_front();
            check_field("rsp_out_red", expected.red, rsp_out_red);
            check_field("rsp_out_green", expected.green, rsp_out_green);
            check_field("rsp_out_blue", expected.blue, rsp_out_blue);
            check_field("rsp_alpha", expected.alpha, rsp_alpha);
            check_field("rsp_last_pixel", {15'd0, expected.last}, {15'd0, rsp_last_pixel});
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].kind == ROW_WRITE)
            write_register(directed_rows[i].index, directed_rows[i].data);
         else
            send_pixel(directed_rows[i].column, directed_rows[i].row,
                       directed_rows[i].known, directed_rows[i].alpha,
                       directed_rows[i].last);
      end
      for (int p = 0; p < PHASE_COUNT; p++) run_phase(p, PHASE_PIXELS);
      start <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d pixels through %0d register writes in %0d random phases.",
               pixels_sent, register_writes, PHASE_COUNT);
      $display("Of these, %0d fell inside the circle and %0d were the last brush pixel.",
               inside_count, last_count);
      if (mismatches == 0) begin
         $display("circular_brush_mask_generator_core_tb: PASS");
      end else begin
         $display("circular_brush_mask_generator_core_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("Run did not complete in the time allowed.");
      $display("circular_brush_mask_generator_core_tb: FAIL");
      $finish;
   end

endmodule
